// File: hw/rtl/mi4_pkg.sv
// mi4_pkg: shared types and constant index tables for the 4x4 matrix inverse
// holds the sequencer state enum, the mac control struct and cofactor tables
// no dependencies
`default_nettype none

package mi4_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SUB_A,
        ST_SUB_B,
        ST_SUB_RUN,
        ST_DET_A,
        ST_DET_B,
        ST_DET_RUN,
        ST_DET_END,
        ST_ADJ_A,
        ST_ADJ_B,
        ST_ADJ_RUN,
        ST_DIV_GO,
        ST_DIV_RUN,
        ST_SING,
        ST_OUT
    } t_state;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic start;
        logic clear;
        logic neg;
    } t_mac_ctl;

    localparam int NUM_ELEM = 16;
    localparam int NUM_SUB  = 12;
    localparam int NUM_DET  = 6;
    localparam int NUM_TERM = 3;

    // 2x2 sub-determinants: s = m[p]*m[q] - m[r]*m[t]
    localparam logic [3:0] SUB_TAB [NUM_SUB][4] = '{
        '{4'd0, 4'd5, 4'd1, 4'd4},   '{4'd0, 4'd6, 4'd2, 4'd4},
        '{4'd0, 4'd7, 4'd3, 4'd4},   '{4'd1, 4'd6, 4'd2, 4'd5},
        '{4'd1, 4'd7, 4'd3, 4'd5},   '{4'd2, 4'd7, 4'd3, 4'd6},
        '{4'd8, 4'd13, 4'd9, 4'd12}, '{4'd8, 4'd14, 4'd10, 4'd12},
        '{4'd8, 4'd15, 4'd11, 4'd12}, '{4'd9, 4'd14, 4'd10, 4'd13},
        '{4'd9, 4'd15, 4'd11, 4'd13}, '{4'd10, 4'd15, 4'd11, 4'd14}
    };

    // determinant: sum of +/- s[a]*s[b]
    localparam logic [3:0] DET_TAB [NUM_DET][2] = '{
        '{4'd0, 4'd11}, '{4'd1, 4'd10}, '{4'd2, 4'd9},
        '{4'd3, 4'd8},  '{4'd4, 4'd7},  '{4'd5, 4'd6}
    };
    localparam logic DET_NEG [NUM_DET] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    // adjugate entry k: sum of three terms +/- m[mi]*s[si]
    localparam logic [3:0] ADJ_MI [NUM_ELEM][NUM_TERM] = '{
        '{4'd5, 4'd6, 4'd7},    '{4'd2, 4'd1, 4'd3},
        '{4'd13, 4'd14, 4'd15}, '{4'd10, 4'd9, 4'd11},
        '{4'd6, 4'd4, 4'd7},    '{4'd0, 4'd2, 4'd3},
        '{4'd14, 4'd12, 4'd15}, '{4'd8, 4'd10, 4'd11},
        '{4'd4, 4'd5, 4'd7},    '{4'd1, 4'd0, 4'd3},
        '{4'd12, 4'd13, 4'd15}, '{4'd9, 4'd8, 4'd11},
        '{4'd5, 4'd4, 4'd6},    '{4'd0, 4'd1, 4'd2},
        '{4'd13, 4'd12, 4'd14}, '{4'd8, 4'd9, 4'd10}
    };
    localparam logic [3:0] ADJ_SI [NUM_ELEM][NUM_TERM] = '{
        '{4'd11, 4'd10, 4'd9}, '{4'd10, 4'd11, 4'd9},
        '{4'd5, 4'd4, 4'd3},   '{4'd4, 4'd5, 4'd3},
        '{4'd8, 4'd11, 4'd7},  '{4'd11, 4'd8, 4'd7},
        '{4'd2, 4'd5, 4'd1},   '{4'd5, 4'd2, 4'd1},
        '{4'd10, 4'd8, 4'd6},  '{4'd8, 4'd10, 4'd6},
        '{4'd4, 4'd2, 4'd0},   '{4'd2, 4'd4, 4'd0},
        '{4'd7, 4'd9, 4'd6},   '{4'd9, 4'd7, 4'd6},
        '{4'd1, 4'd3, 4'd0},   '{4'd3, 4'd1, 4'd0}
    };
    // sign of the third adjugate term (first is always added, second subtracted)
    localparam logic ADJ_NEG3 [NUM_ELEM] = '{
        1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
        1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0
    };

endpackage

`default_nettype wire

// File: hw/rtl/mi4_mac.sv
// mi4_mac: shift-add signed multiply-accumulate, one multiplier bit per cycle
// accumulates +/- mcand * mplier into a wide two's complement accumulator
// depends on mi4_pkg
`default_nettype none

module mi4_mac #(
    parameter int AW = 164,
    parameter int MB = 66
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mi4_pkg::t_mac_ctl i_ctl,
    input  wire logic [AW-1:0]     i_mcand,
    input  wire logic [MB-1:0]     i_mplier,
    output logic                   o_busy,
    output logic [AW-1:0]          o_acc
);
    import mi4_pkg::*;

    localparam int CW = $clog2(MB + 1);

    logic [AW-1:0] r_a;
    logic [MB-1:0] r_b;
    logic [CW-1:0] r_cnt;
    logic          r_neg;
    logic [AW-1:0] r_acc;
    logic          w_sub;

    // the top multiplier bit carries negative weight
    assign w_sub  = r_neg ^ (r_cnt == CW'(1));
    assign o_busy = (r_cnt != '0);
    assign o_acc  = r_acc;

    // iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.start) begin
            r_cnt <= CW'(MB);
        end else if (o_busy) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    // operand shift and accumulate
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a   <= i_mcand;
            r_b   <= i_mplier;
            r_neg <= i_ctl.neg;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end
        end else if (o_busy) begin
            r_a <= {r_a[AW-2:0], 1'b0};
            r_b <= {1'b0, r_b[MB-1:1]};
            if (r_b[0]) begin
                r_acc <= w_sub ? (r_acc - r_a) : (r_acc + r_a);
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/mi4_div.sv
// mi4_div: restoring unsigned divider, one quotient bit per cycle
// quotient of two AW-bit non-negative values, remainder discarded
// depends on mi4_pkg
`default_nettype none

module mi4_div #(
    parameter int AW = 164
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [AW-1:0] i_num,
    input  wire logic [AW-1:0] i_den,
    output logic               o_busy,
    output logic [AW-1:0]      o_quot
);
    import mi4_pkg::*;

    localparam int CW = $clog2(AW + 1);

    logic [AW-1:0] r_rem;
    logic [AW-1:0] r_q;
    logic [AW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic [AW:0]   w_trial;
    logic [AW:0]   w_diff;

    assign w_trial = {r_rem, r_q[AW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign o_busy  = (r_cnt != '0);
    assign o_quot  = r_q;

    // iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(AW);
        end else if (o_busy) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    // shift in dividend bits, subtract when the divisor fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (o_busy) begin
            if (!w_diff[AW]) begin
                r_rem <= w_diff[AW-1:0];
                r_q   <= {r_q[AW-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[AW-1:0];
                r_q   <= {r_q[AW-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/mat4_inverse_top.sv
// a matrix enters as 16 input beats, then the sub-determinants and the determinant are
//   formed, and each of the 16 result beats follows its own adjugate entry and divide
// a singular matrix skips the adjugate: results follow the determinant directly
// throughput: one matrix at a time, set by the bit-serial mac and divider
// reset: synchronous active low, clears sequencer, counters and output valid
`default_nettype none

module mat4_inverse_top #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_element_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_result_value,
    output logic [3:0]              o_result_index,
    output logic                    o_singular,
    output logic                    o_saturated,
    output logic                    o_last_result
);
    import mi4_pkg::*;

    localparam int W  = ELEMENT_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int SW = 2 * W + 2;
    localparam int AW = 4 * W + 2 * F + 4;

    t_state          r_state, n_state;
    logic [3:0]      r_cnt;
    logic [3:0]      r_k;
    logic [2:0]      r_t;
    logic [W-1:0]    r_mat [NUM_ELEM];
    logic [SW-1:0]   r_s [NUM_SUB];
    logic [AW-1:0]   r_opa;
    logic [AW-1:0]   r_dabs;
    logic            r_dneg;
    logic            r_sing;
    logic            r_qneg;
    logic            r_ovalid;
    logic [31:0]     r_oval;
    logic [3:0]      r_oidx;
    logic            r_osing;
    logic            r_osat;

    t_mac_ctl        w_mac;
    logic            w_mac_busy;
    logic [AW-1:0]   w_acc;
    logic            w_div_start;
    logic            w_div_busy;
    logic [AW-1:0]   w_quot;
    logic [AW-1:0]   w_num;
    logic [AW-1:0]   w_acc_abs;
    logic [3:0]      m_addr;
    logic [3:0]      s_addr;
    logic [W-1:0]    m_rd;
    logic [SW-1:0]   s_rd;
    logic [SW-1:0]   w_mplier;
    logic            w_in_beat;
    logic            w_out_beat;
    logic            w_det_zero;
    logic            w_div_done;
    logic [W-1:0]    w_elem;
    logic [AW-1:0]   w_lim;
    logic [W-1:0]    w_qval;
    logic            w_qsat;
    logic [95:0]     w_wide_in;

    assign w_in_beat  = i_valid && o_ready;
    assign w_out_beat = r_ovalid && i_ready;
    assign w_det_zero = (w_acc == '0);
    assign w_div_done = (r_state == ST_DIV_RUN) && !w_div_busy;
    assign w_acc_abs  = w_acc[AW-1] ? (-w_acc) : w_acc;
    assign w_num      = w_acc_abs << (2 * F);
    assign w_wide_in  = 96'(unsigned'(i_element_value));
    assign w_elem     = w_wide_in[W-1:0];

    // store read ports, one address each per cycle
    always_comb begin
        m_addr = r_k;
        s_addr = '0;
        case (r_state)
            ST_SUB_A: m_addr = SUB_TAB[r_k][{r_t[0], 1'b0}];
            ST_SUB_B: m_addr = SUB_TAB[r_k][{r_t[0], 1'b1}];
            ST_DET_A: s_addr = DET_TAB[r_t][0];
            ST_DET_B: s_addr = DET_TAB[r_t][1];
            ST_ADJ_A: s_addr = ADJ_SI[r_k][r_t[1:0]];
            ST_ADJ_B: m_addr = ADJ_MI[r_k][r_t[1:0]];
            default:  m_addr = r_k;
        endcase
    end
    assign m_rd = r_mat[m_addr];
    assign s_rd = r_s[s_addr];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:    if (w_in_beat && r_cnt == 4'd15) n_state = ST_SUB_A;
            ST_SUB_A:   n_state = ST_SUB_B;
            ST_SUB_B:   n_state = ST_SUB_RUN;
            ST_SUB_RUN: begin
                if (!w_mac_busy) begin
                    if (r_t[0] && r_k == 4'(NUM_SUB - 1)) n_state = ST_DET_A;
                    else                                  n_state = ST_SUB_A;
                end
            end
            ST_DET_A:   n_state = ST_DET_B;
            ST_DET_B:   n_state = ST_DET_RUN;
            ST_DET_RUN: begin
                if (!w_mac_busy) begin
                    n_state = (r_t == 3'(NUM_DET - 1)) ? ST_DET_END : ST_DET_A;
                end
            end
            ST_DET_END: n_state = w_det_zero ? ST_SING : ST_ADJ_A;
            ST_ADJ_A:   n_state = ST_ADJ_B;
            ST_ADJ_B:   n_state = ST_ADJ_RUN;
            ST_ADJ_RUN: begin
                if (!w_mac_busy) begin
                    n_state = (r_t == 3'(NUM_TERM - 1)) ? ST_DIV_GO : ST_ADJ_A;
                end
            end
            ST_DIV_GO:  n_state = ST_DIV_RUN;
            ST_DIV_RUN: if (!w_div_busy) n_state = ST_OUT;
            ST_SING:    n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_beat) begin
                    if (r_k == 4'd15) n_state = ST_LOAD;
                    else              n_state = r_sing ? ST_SING : ST_ADJ_A;
                end
            end
            default:    n_state = ST_LOAD;
        endcase
    end

    // unit controls
    always_comb begin
        w_mac       = '0;
        w_div_start = 1'b0;
        w_mplier    = SW'(signed'(m_rd));
        o_ready     = 1'b0;
        case (r_state)
            ST_LOAD:  o_ready = 1'b1;
            ST_SUB_B: begin
                w_mac.start = 1'b1;
                w_mac.clear = !r_t[0];
                w_mac.neg   = r_t[0];
            end
            ST_DET_B: begin
                w_mac.start = 1'b1;
                w_mac.clear = (r_t == '0);
                w_mac.neg   = DET_NEG[r_t];
                w_mplier    = s_rd;
            end
            ST_ADJ_B: begin
                w_mac.start = 1'b1;
                w_mac.clear = (r_t == '0);
                w_mac.neg   = (r_t == 3'd1) || (r_t == 3'd2 && ADJ_NEG3[r_k]);
            end
            ST_DIV_GO: w_div_start = 1'b1;
            default:   w_mac = '0;
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_k     <= '0;
            r_t     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_LOAD: begin
                    if (w_in_beat) begin
                        r_cnt <= r_cnt + 4'd1;
                        r_k   <= '0;
                        r_t   <= '0;
                    end
                end
                ST_SUB_RUN: begin
                    if (!w_mac_busy) begin
                        if (r_t[0]) begin
                            r_t <= '0;
                            r_k <= (r_k == 4'(NUM_SUB - 1)) ? 4'd0 : r_k + 4'd1;
                        end else begin
                            r_t <= 3'd1;
                        end
                    end
                end
                ST_DET_RUN: if (!w_mac_busy) r_t <= r_t + 3'd1;
                ST_DET_END: begin
                    r_k <= '0;
                    r_t <= '0;
                end
                ST_ADJ_RUN: if (!w_mac_busy) r_t <= r_t + 3'd1;
                ST_DIV_GO:  r_t <= '0;
                ST_OUT:     if (w_out_beat) r_k <= r_k + 4'd1;
                default:    r_t <= r_t;
            endcase
        end
    end

    // matrix, sub-determinant and determinant storage, mac operand and quotient sign
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_mat[r_cnt] <= w_elem;
        end
        if (r_state == ST_SUB_A || r_state == ST_ADJ_A) begin
            r_opa <= (r_state == ST_SUB_A) ? AW'(signed'(m_rd)) : AW'(signed'(s_rd));
        end
        if (r_state == ST_DET_A) begin
            r_opa <= AW'(signed'(s_rd));
        end
        if (r_state == ST_SUB_RUN && !w_mac_busy && r_t[0]) begin
            r_s[r_k] <= w_acc[SW-1:0];
        end
        if (r_state == ST_DET_END) begin
            r_dabs <= w_acc_abs;
            r_dneg <= w_acc[AW-1];
        end
        if (r_state == ST_DIV_GO) begin
            r_qneg <= w_acc[AW-1] ^ r_dneg;
        end
    end

    // singular flag is control state for the emit loop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sing <= 1'b0;
        end else if (r_state == ST_DET_END) begin
            r_sing <= w_det_zero;
        end
    end

    // quotient saturation to the element range
    always_comb begin
        w_lim  = AW'(1) << (W - 1);
        w_qsat = r_qneg ? (w_quot > w_lim) : (w_quot >= w_lim);
        if (w_qsat) begin
            w_qval = r_qneg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            w_qval = r_qneg ? (-w_quot[W-1:0]) : w_quot[W-1:0];
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_div_done || r_state == ST_SING) begin
            r_ovalid <= 1'b1;
        end else if (w_out_beat) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            r_oval  <= 32'(96'(w_qval));
            r_oidx  <= r_k;
            r_osing <= 1'b0;
            r_osat  <= w_qsat;
        end else if (r_state == ST_SING) begin
            r_oval  <= 32'(96'(m_rd));
            r_oidx  <= r_k;
            r_osing <= 1'b1;
            r_osat  <= 1'b0;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_result_value = r_oval;
    assign o_result_index = r_oidx;
    assign o_singular     = r_osing;
    assign o_saturated    = r_osat;
    assign o_last_result  = (r_oidx == 4'd15);

    mi4_mac #(
        .AW(AW),
        .MB(SW)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac),
        .i_mcand  (r_opa),
        .i_mplier (w_mplier),
        .o_busy   (w_mac_busy),
        .o_acc    (w_acc)
    );

    mi4_div #(
        .AW(AW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_dabs),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // a result beat is only offered while the sequencer waits on it
    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_state == ST_OUT))
        else $error("result beat outside output wait");

    // a passed-through element is never flagged as clamped
    a_sing_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_osing) |-> !r_osat)
        else $error("singular result flagged saturated");

    // the final result beat returns the block to loading with an empty count
    a_last_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && w_out_beat && r_k == 4'd15)
            |=> (r_state == ST_LOAD && r_cnt == 4'd0))
        else $error("run did not end in load state");

    // units are never restarted while running
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mac.start && w_mac_busy) && !(w_div_start && w_div_busy))
        else $error("shared unit restarted while busy");

endmodule

`default_nettype wire
